[sv/mtk_pkg.sv]
// Package: codes, types and character tables for the multi-tap text entry block.
`timescale 1ns / 1ps

package mtk_pkg;

  // Text store size that the consumer keeps
  localparam int TEXT_CAPACITY = 128;
  localparam int LEN_LIMIT_I   = (TEXT_CAPACITY - 1 > 127) ? 127 : (TEXT_CAPACITY - 1);
  localparam logic [6:0] LEN_LIMIT = 7'(LEN_LIMIT_I);

  localparam logic [15:0] TIMEOUT_RESET = 16'd600;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_TICK  = 2'd1,
    OP_BACK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_DELETE  = 3'd3,
    ACT_CLEARED = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_LOWER   = 2'd0,
    MODE_UPPER   = 2'd1,
    MODE_NUMERIC = 2'd2
  } mode_t;

  localparam logic [3:0] KEY_ASTERISK = 4'd10;
  localparam logic [3:0] KEY_POUND    = 4'd11;

  // One result request
  typedef struct packed {
    logic [2:0] action;
    logic [6:0] char_code;
    logic [6:0] text_length;
    logic [1:0] mode;
  } result_t;

  // Lower-case character lists, one row per key (digits, then asterisk)
  localparam logic [7:0] LOWER_TABLE [0:10][0:11] = '{
    '{" ", "0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", ",", "!", "?", "'", "-", "@", "#", "$", "%", "&", "1"},
    '{"a", "b", "c", "2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "e", "f", "3", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "h", "i", "4", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"j", "k", "l", "5", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "n", "o", "6", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "q", "r", "s", "7", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "u", "v", "8", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "x", "y", "z", "9", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] LIST_LEN [0:10] = '{
    4'd2, 4'd12, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd5, 4'd2
  };

  localparam logic [7:0] NUMERIC_STAR [0:2] = '{"+", "*", "#"};

  // Length of a key's list in the given mode (key is a digit or asterisk)
  function automatic logic [3:0] list_len(input logic [1:0] mode, input logic [3:0] key);
    logic [3:0] len;
    len = 4'd1;
    if (mode == MODE_NUMERIC) begin
      len = (key == KEY_ASTERISK) ? 4'd3 : 4'd1;
    end else if (key <= KEY_ASTERISK) begin
      len = LIST_LEN[key];
    end
    return len;
  endfunction

  // Character at a list position in the given mode
  function automatic logic [6:0] list_char(input logic [1:0] mode, input logic [3:0] key,
                                           input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (mode == MODE_NUMERIC) begin
      if (key == KEY_ASTERISK) begin
        if (pos < 4'd3) begin
          c = NUMERIC_STAR[pos[1:0]];
        end
      end else begin
        c = 8'h30 + {4'd0, key};
      end
    end else if (key <= KEY_ASTERISK && pos < 4'd12) begin
      c = LOWER_TABLE[key][pos];
      if (mode == MODE_UPPER && c >= "a" && c <= "z") begin
        c = c - 8'd32;
      end
    end
    return c[6:0];
  endfunction

  // Mode order: lower -> upper -> numeric -> lower
  function automatic logic [1:0] step_mode(input logic [1:0] mode);
    logic [1:0] m;
    case (mode)
      MODE_LOWER: m = MODE_UPPER;
      MODE_UPPER: m = MODE_NUMERIC;
      default:    m = MODE_LOWER;
    endcase
    return m;
  endfunction

endpackage

[sv/mtk_core.sv]
// Tap state registers and the single-pass next-state and result logic.
`timescale 1ns / 1ps

module mtk_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_data,
  input  logic             accept,
  input  logic [1:0]       operation,
  input  logic [3:0]       key,
  output mtk_pkg::result_t result
);
  import mtk_pkg::*;

  logic [15:0] timeout_val;
  logic        pending_valid, pending_valid_next;
  logic [3:0]  pending_key, pending_key_next;
  logic [3:0]  cycle_position, cycle_position_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [1:0]  case_mode, case_mode_next;
  logic [6:0]  length_count, length_count_next;

  logic [15:0] elapsed_inc;
  logic [3:0]  pos_inc;
  logic [3:0]  cur_len;
  logic        is_repeat;

  // Next state and result for the request at the inputs
  always_comb begin
    pending_valid_next  = pending_valid;
    pending_key_next    = pending_key;
    cycle_position_next = cycle_position;
    elapsed_ms_next     = elapsed_ms;
    case_mode_next      = case_mode;
    length_count_next   = length_count;
    result.action       = ACT_NONE;
    result.char_code    = 7'd0;

    elapsed_inc = (elapsed_ms != 16'hFFFF) ? (elapsed_ms + 16'd1) : elapsed_ms;
    cur_len     = list_len(case_mode, key);
    pos_inc     = cycle_position + 4'd1;
    is_repeat   = pending_valid && (pending_key == key) && (elapsed_ms < timeout_val);

    case (operation)
      OP_KEY: begin
        if (key == KEY_POUND) begin
          pending_valid_next  = 1'b0;
          pending_key_next    = 4'd0;
          cycle_position_next = 4'd0;
          case_mode_next      = step_mode(case_mode);
        end else if (key <= KEY_ASTERISK) begin
          if (is_repeat) begin
            cycle_position_next = (pos_inc >= cur_len) ? 4'd0 : pos_inc;
            if (length_count != 7'd0) begin
              result.action    = ACT_REPLACE;
              result.char_code = list_char(case_mode, key, cycle_position_next);
            end
            elapsed_ms_next = 16'd0;
          end else if (length_count < LEN_LIMIT) begin
            pending_valid_next  = 1'b1;
            pending_key_next    = key;
            cycle_position_next = 4'd0;
            elapsed_ms_next     = 16'd0;
            length_count_next   = length_count + 7'd1;
            result.action       = ACT_APPEND;
            result.char_code    = list_char(case_mode, key, 4'd0);
          end else begin
            pending_valid_next  = 1'b0;
            pending_key_next    = 4'd0;
            cycle_position_next = 4'd0;
            elapsed_ms_next     = 16'd0;
          end
        end
      end
      OP_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (pending_valid && elapsed_inc >= timeout_val) begin
          pending_valid_next  = 1'b0;
          pending_key_next    = 4'd0;
          cycle_position_next = 4'd0;
        end
      end
      OP_BACK: begin
        pending_valid_next  = 1'b0;
        pending_key_next    = 4'd0;
        cycle_position_next = 4'd0;
        if (length_count != 7'd0) begin
          length_count_next = length_count - 7'd1;
          result.action     = ACT_DELETE;
        end
      end
      default: begin
        pending_valid_next  = 1'b0;
        pending_key_next    = 4'd0;
        cycle_position_next = 4'd0;
        length_count_next   = 7'd0;
        result.action       = ACT_CLEARED;
      end
    endcase

    result.text_length = length_count_next;
    result.mode        = case_mode_next;
  end

  // State update on each accepted request; timeout register on writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_val    <= TIMEOUT_RESET;
      pending_valid  <= 1'b0;
      pending_key    <= 4'd0;
      cycle_position <= 4'd0;
      elapsed_ms     <= 16'd0;
      case_mode      <= MODE_LOWER;
      length_count   <= 7'd0;
    end else begin
      if (cfg_write) begin
        timeout_val <= cfg_data;
      end
      if (accept) begin
        pending_valid  <= pending_valid_next;
        pending_key    <= pending_key_next;
        cycle_position <= cycle_position_next;
        elapsed_ms     <= elapsed_ms_next;
        case_mode      <= case_mode_next;
        length_count   <= length_count_next;
      end
    end
  end

endmodule

[sv/mtk_out_buf.sv]
// Output register with a skid stage between the core and the result channel.
`timescale 1ns / 1ps

module mtk_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mtk_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output mtk_pkg::result_t out_data
);
  import mtk_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Main register feeds the port; skid catches a request while main is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= push;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[sv/multi_tap_keypad_text_entry.sv]
// Multi-tap keypad text entry: top level.
// Each result is registered in the output register, or in the skid if that is held.
// Throughput: one request per cycle unless in_stall is high; the state update and
// table lookup share one combinational pass into the tap-state and output registers.
// Reset (synchronous): no pending tap, lower-case mode, empty text, timeout 600 ms,
// no result held.
`timescale 1ns / 1ps

module multi_tap_keypad_text_entry (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [6:0]  char_code,
  output logic [6:0]  text_length,
  output logic [1:0]  mode
);
  import mtk_pkg::*;

  logic    accept;
  logic    buf_full;
  result_t core_result;
  result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Tap state and edit logic
  mtk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .operation (operation),
    .key       (key),
    .result    (core_result)
  );

  // Result register and skid
  mtk_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign action      = out_data.action;
  assign char_code   = out_data.char_code;
  assign text_length = out_data.text_length;
  assign mode        = out_data.mode;

endmodule

[dv/multi_tap_keypad_text_entry_tb.sv]
// Self-checking testbench for the multi-tap keypad text entry block.
`timescale 1ns / 1ps

module multi_tap_keypad_text_entry_tb;
  import mtk_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 104;
  localparam int NUM_PHASES   = 8;
  localparam int LEN_CAP      = (TEXT_CAPACITY - 1 > 127) ? 127 : (TEXT_CAPACITY - 1);

  // One row of the directed table; pinned rows carry a hand-typed result
  typedef struct packed {
    op_t        op;
    logic [3:0] key_code;
    bit         pinned;
    result_t    res;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = 2'd0;
  logic [3:0]  key = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [6:0]  char_code;
  logic [6:0]  text_length;
  logic [1:0]  mode;

  // Typed-in expectation travels with the request payload
  bit          pin_en = 1'b0;
  result_t     pin_res = '0;

  // Predictor state
  logic [15:0] timeout_cfg;
  bit          tap_open;
  logic [3:0]  tap_key;
  logic [3:0]  tap_pos;
  logic [15:0] ms_since_tap;
  mode_t       case_sel;
  int          text_len;

  result_t     expected_edits [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          sink_hold = 0;
  bit          calm = 1'b0;
  int          timeout_now = 600;
  step_t       plan [27];

  always #10 clk = ~clk;

  multi_tap_keypad_text_entry u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .char_code   (char_code),
    .text_length (text_length),
    .mode        (mode)
  );

  // Characters behind a digit or asterisk key in lower case
  function automatic string key_list(logic [3:0] k);
    case (k)
      4'd0:    return " 0";
      4'd1:    return ".,!?'-@#$%&1";
      4'd2:    return "abc2";
      4'd3:    return "def3";
      4'd4:    return "ghi4";
      4'd5:    return "jkl5";
      4'd6:    return "mno6";
      4'd7:    return "pqrs7";
      4'd8:    return "tuv8";
      4'd9:    return "wxyz9";
      default: return "+*";
    endcase
  endfunction

  function automatic int list_size(logic [3:0] k);
    string s;
    if (case_sel == MODE_NUMERIC) begin
      return (k == KEY_ASTERISK) ? 3 : 1;
    end
    s = key_list(k);
    return s.len();
  endfunction

  function automatic logic [6:0] glyph_for(logic [3:0] k, logic [3:0] pos);
    string s;
    string star_set;
    byte   c;
    star_set = "+*#";
    if (case_sel == MODE_NUMERIC) begin
      if (k == KEY_ASTERISK) begin
        c = star_set[pos % 3];
        return c[6:0];
      end
      return 7'h30 + {3'd0, k};
    end
    s = key_list(k);
    c = s[pos % s.len()];
    if (case_sel == MODE_UPPER && c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    return c[6:0];
  endfunction

  function automatic void close_tap();
    tap_open = 1'b0;
    tap_key  = 4'd0;
    tap_pos  = 4'd0;
  endfunction

  // Edit that one accepted request should produce; advances the tap state
  function automatic result_t predict_edit(op_t op, logic [3:0] k);
    result_t r;
    r = '0;
    r.action = ACT_NONE;
    case (op)
      OP_KEY: begin
        if (k == KEY_POUND) begin
          close_tap();
          case (case_sel)
            MODE_LOWER: case_sel = MODE_UPPER;
            MODE_UPPER: case_sel = MODE_NUMERIC;
            default:    case_sel = MODE_LOWER;
          endcase
        end else if (k <= KEY_ASTERISK) begin
          if (tap_open && tap_key == k && ms_since_tap < timeout_cfg) begin
            // repeat tap: step through the list
            tap_pos = 4'((tap_pos + 1) % list_size(k));
            if (text_len > 0) begin
              r.action    = ACT_REPLACE;
              r.char_code = glyph_for(k, tap_pos);
            end
            ms_since_tap = 16'd0;
          end else if (text_len < LEN_CAP) begin
            tap_open     = 1'b1;
            tap_key      = k;
            tap_pos      = 4'd0;
            ms_since_tap = 16'd0;
            text_len++;
            r.action     = ACT_APPEND;
            r.char_code  = glyph_for(k, 4'd0);
          end else begin
            // text full: no new tap
            close_tap();
            ms_since_tap = 16'd0;
          end
        end
      end
      OP_TICK: begin
        if (ms_since_tap != 16'hFFFF) ms_since_tap++;
        if (tap_open && ms_since_tap >= timeout_cfg) close_tap();
      end
      OP_BACK: begin
        close_tap();
        if (text_len > 0) begin
          text_len--;
          r.action = ACT_DELETE;
        end
      end
      default: begin
        close_tap();
        text_len = 0;
        r.action = ACT_CLEARED;
      end
    endcase
    r.text_length = text_len[6:0];
    r.mode        = case_sel;
    return r;
  endfunction

  task automatic check_field(string what, int exp, int got);
    if (exp != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp, got);
      mismatches++;
    end
  endtask

  // Results are checked first, then new requests are predicted
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      timeout_cfg  = TIMEOUT_RESET;
      close_tap();
      ms_since_tap = 16'd0;
      case_sel     = MODE_LOWER;
      text_len     = 0;
      expected_edits.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_edits.size() == 0) begin
          $display("%0t: unexpected result: action %0d char %0d length %0d mode %0d",
                   $time, action, char_code, text_length, mode);
          mismatches++;
        end else begin
          r = expected_edits.pop_front();
          check_field("action", r.action, action);
          check_field("char_code", r.char_code, char_code);
          check_field("text_length", r.text_length, text_length);
          check_field("mode", r.mode, mode);
        end
      end
      if (cfg_write) timeout_cfg = cfg_data;
      if (in_valid && !in_stall) begin
        r = predict_edit(op_t'(operation), key);
        expected_edits.push_back(pin_en ? pin_res : r);
      end
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      sink_hold = $urandom_range(0, 6);
    end else begin
      sink_hold = idle_gap();
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one request and wait until it is taken; valid stays high afterwards
  task automatic press(op_t op, logic [3:0] k, bit pin, result_t pinned);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    pin_en    <= pin;
    pin_res   <= pinned;
    do @(posedge clk); while (in_stall);
    if (!(op == OP_KEY && k > KEY_POUND)) items_sent++;
  endtask

  // Hold off requests until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_edits.size() != 0) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_timeout(logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    timeout_now = v;
  endtask

  function automatic step_t row(op_t op, logic [3:0] k, bit pin, action_t act,
                                logic [7:0] ch, int len, mode_t md);
    step_t s;
    s.op                = op;
    s.key_code          = k;
    s.pinned            = pin;
    s.res.action        = act;
    s.res.char_code     = ch[6:0];
    s.res.text_length   = len[6:0];
    s.res.mode          = md;
    return s;
  endfunction

  initial begin
    int k_sel, taps, n, tb, pick, phase_start;
    logic [15:0] tmo;

    // Directed table, default timeout of 600 ms
    plan = '{
      row(OP_KEY,   4'd2,         1, ACT_APPEND,  "a",  1, MODE_LOWER),
      row(OP_KEY,   4'd2,         1, ACT_REPLACE, "b",  1, MODE_LOWER),
      row(OP_KEY,   4'd2,         0, ACT_NONE,    8'd0, 0, MODE_LOWER),
      row(OP_KEY,   4'd2,         0, ACT_NONE,    8'd0, 0, MODE_LOWER),
      row(OP_KEY,   4'd2,         1, ACT_REPLACE, "a",  1, MODE_LOWER),
      row(OP_KEY,   4'd7,         1, ACT_APPEND,  "p",  2, MODE_LOWER),
      row(OP_TICK,  4'd0,         1, ACT_NONE,    8'd0, 2, MODE_LOWER),
      row(OP_KEY,   4'd7,         1, ACT_REPLACE, "q",  2, MODE_LOWER),
      row(OP_KEY,   KEY_POUND,    1, ACT_NONE,    8'd0, 2, MODE_UPPER),
      row(OP_KEY,   4'd7,         1, ACT_APPEND,  "P",  3, MODE_UPPER),
      row(OP_KEY,   4'd0,         1, ACT_APPEND,  " ",  4, MODE_UPPER),
      row(OP_KEY,   4'd0,         1, ACT_REPLACE, "0",  4, MODE_UPPER),
      row(OP_KEY,   KEY_POUND,    1, ACT_NONE,    8'd0, 4, MODE_NUMERIC),
      row(OP_KEY,   KEY_ASTERISK, 1, ACT_APPEND,  "+",  5, MODE_NUMERIC),
      row(OP_KEY,   KEY_ASTERISK, 0, ACT_NONE,    8'd0, 0, MODE_NUMERIC),
      row(OP_KEY,   KEY_ASTERISK, 1, ACT_REPLACE, "#",  5, MODE_NUMERIC),
      row(OP_KEY,   KEY_ASTERISK, 1, ACT_REPLACE, "+",  5, MODE_NUMERIC),
      row(OP_KEY,   4'd9,         1, ACT_APPEND,  "9",  6, MODE_NUMERIC),
      row(OP_KEY,   4'd9,         0, ACT_NONE,    8'd0, 0, MODE_NUMERIC),
      row(OP_KEY,   4'd12,        1, ACT_NONE,    8'd0, 6, MODE_NUMERIC),
      row(OP_KEY,   4'd15,        1, ACT_NONE,    8'd0, 6, MODE_NUMERIC),
      row(OP_KEY,   KEY_POUND,    1, ACT_NONE,    8'd0, 6, MODE_LOWER),
      row(OP_KEY,   4'd1,         1, ACT_APPEND,  ".",  7, MODE_LOWER),
      row(OP_BACK,  4'd0,         1, ACT_DELETE,  8'd0, 6, MODE_LOWER),
      row(OP_CLEAR, 4'd15,        1, ACT_CLEARED, 8'd0, 0, MODE_LOWER),
      row(OP_BACK,  4'd0,         1, ACT_NONE,    8'd0, 0, MODE_LOWER),
      row(OP_KEY,   KEY_ASTERISK, 1, ACT_APPEND,  "+",  1, MODE_LOWER)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(plan); i++) begin
      press(plan[i].op, plan[i].key_code, plan[i].pinned, plan[i].res);
    end
    drain();

    // Random phases, each with its own timeout
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       tmo = 16'd1;
        1:       tmo = 16'd0;
        2:       tmo = 16'hFFFF;
        3:       tmo = 16'd2;
        4:       tmo = 16'd3;
        5:       tmo = 16'd5;
        6:       tmo = 16'($urandom_range(1, 12));
        default: tmo = 16'($urandom_range(1, 65535));
      endcase
      set_timeout(tmo);
      phase_start = items_sent;

      // Fill the text to its limit, with some repeats landing at the limit
      if (ph == 1 || ph == 5) begin
        for (int i = 0; i < 134; i++) begin
          k_sel = (i % 2) ? 3 : 8;
          press(OP_KEY, 4'(k_sel), 0, '0);
          if ($urandom_range(0, 2) == 0) press(OP_KEY, 4'(k_sel), 0, '0);
        end
      end

      while (items_sent - phase_start < PHASE_ITEMS) begin
        calm = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        tb   = (timeout_now > 12) ? 12 : timeout_now;
        if (pick < 60) begin
          // tap burst on one key with ticks in between
          k_sel = $urandom_range(0, 10);
          taps  = $urandom_range(1, 14);
          for (int t = 0; t < taps; t++) begin
            press(OP_KEY, 4'(k_sel), 0, '0);
            if (t < taps - 1) begin
              if ($urandom_range(0, 3) != 0) n = (tb > 0) ? $urandom_range(0, tb - 1) : 0;
              else n = $urandom_range(tb, tb + 2);
              repeat (n) press(OP_TICK, 4'($urandom_range(0, 15)), 0, '0);
            end
          end
        end else if (pick < 72) begin
          n = $urandom_range(1, tb + 3);
          repeat (n) press(OP_TICK, 4'($urandom_range(0, 15)), 0, '0);
        end else if (pick < 80) begin
          press(OP_KEY, KEY_POUND, 0, '0);
        end else if (pick < 88) begin
          n = $urandom_range(1, 3);
          repeat (n) press(OP_BACK, 4'($urandom_range(0, 15)), 0, '0);
        end else if (pick < 91) begin
          press(OP_CLEAR, 4'($urandom_range(0, 15)), 0, '0);
        end else if (pick < 95) begin
          press(OP_KEY, 4'($urandom_range(12, 15)), 0, '0);
        end else if (pick < 99) begin
          press(op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 0, '0);
        end else begin
          drain();
        end
      end
      calm = 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
